// ===== rtl/core/gef_pkg.sv =====
`default_nettype none
package gef_pkg;

  // Sample format; the internal signal path is Q1.31.
  localparam int SAMPLE_BITS = 24;
  localparam int SAMPLE_PAD  = 32 - SAMPLE_BITS;
  localparam int DATA_W      = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int MIX_SHIFT   = 16 + SAMPLE_PAD;

  // Envelope and mix constants.
  localparam logic [23:0] ENV_ONE = 24'd4194304;
  localparam logic [23:0] ENV_TWO = 24'd8388608;
  localparam logic [16:0] WET_ONE = 17'd65536;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_ADDR_W-1:0] REG_GATE_THRESHOLD    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ATTACK_RATE       = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_TREBLE_DECAY_MULT = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_BASS_DECAY_MULT   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_WET_MIX           = 3'd4;

  localparam logic [22:0] RST_GATE_THRESHOLD = 23'd0;
  localparam logic [23:0] RST_ATTACK_RATE    = 24'd12583;
  localparam logic [23:0] RST_DECAY_MULT     = 24'd16777215;
  localparam logic [16:0] RST_WET_MIX        = 17'd65536;

  typedef struct packed {
    logic [22:0] gate_threshold;
    logic [23:0] attack_rate;
    logic [23:0] treble_decay_mult;
    logic [23:0] bass_decay_mult;
    logic [16:0] wet_mix;
  } cfg_t;

endpackage
`default_nettype wire

// ===== rtl/core/gef_cfg_regs.sv =====
`default_nettype none
module gef_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [gef_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  wire logic [gef_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output gef_pkg::cfg_t                         cfg
);

  gef_pkg::cfg_t cfg_r;

  // Each write keeps only as many bits as the register holds.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gate_threshold    <= gef_pkg::RST_GATE_THRESHOLD;
      cfg_r.attack_rate       <= gef_pkg::RST_ATTACK_RATE;
      cfg_r.treble_decay_mult <= gef_pkg::RST_DECAY_MULT;
      cfg_r.bass_decay_mult   <= gef_pkg::RST_DECAY_MULT;
      cfg_r.wet_mix           <= gef_pkg::RST_WET_MIX;
    end else if (cfg_we) begin
      case (cfg_addr)
        gef_pkg::REG_GATE_THRESHOLD:    cfg_r.gate_threshold    <= cfg_wdata[22:0];
        gef_pkg::REG_ATTACK_RATE:       cfg_r.attack_rate       <= cfg_wdata[23:0];
        gef_pkg::REG_TREBLE_DECAY_MULT: cfg_r.treble_decay_mult <= cfg_wdata[23:0];
        gef_pkg::REG_BASS_DECAY_MULT:   cfg_r.bass_decay_mult   <= cfg_wdata[23:0];
        gef_pkg::REG_WET_MIX:           cfg_r.wet_mix           <= cfg_wdata[16:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// ===== rtl/core/gef_mul.sv =====
`default_nettype none
module gef_mul (
  input  wire logic               clk,
  input  wire logic signed [32:0] op_a,
  input  wire logic        [23:0] op_b,
  output logic signed      [56:0] prod
);

  logic signed [56:0] full;
  logic signed [56:0] prod_r;

  // Unsigned operand is widened by one zero bit so the product stays signed.
  assign full = op_a * $signed({1'b0, op_b});

  always_ff @(posedge clk) begin
    prod_r <= full;
  end

  assign prod = prod_r;

endmodule
`default_nettype wire

// ===== rtl/core/gef_core.sv =====
`default_nettype none
module gef_core (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire gef_pkg::cfg_t                        cfg,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic signed [gef_pkg::SAMPLE_BITS-1:0] in_sample,
  input  wire logic                                 slot_free,
  output logic                                      res_valid,
  output logic signed [gef_pkg::SAMPLE_BITS-1:0]    res_sample
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_ATK_MUL, ST_ATK_USE, ST_GATE, ST_DT_MUL, ST_DT_USE, ST_DB_MUL,
    ST_DB_USE, ST_LP_MUL, ST_LP_USE, ST_HP_MUL, ST_HP_USE, ST_MD_MUL,
    ST_MW_MUL, ST_MW_USE, ST_DONE
  } state_t;

  localparam logic signed [57:0] SAT_HI =
    58'((64'sd1 <<< (gef_pkg::SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [57:0] SAT_LO =
    58'(-(64'sd1 <<< (gef_pkg::SAMPLE_BITS - 1)));

  state_t             state_r, state_nxt;
  logic               phase_r, phase_nxt;
  logic        [23:0] treble_r, treble_nxt;
  logic        [23:0] bass_r, bass_nxt;
  logic signed [31:0] x_r, x_nxt;
  logic        [31:0] mag_r, mag_nxt;
  logic        [23:0] atk_r, atk_nxt;
  // Index 0 is the even pair, index 1 the odd pair; the phase bit selects.
  logic signed [31:0] lp_r [2];
  logic signed [31:0] lp_nxt [2];
  logic signed [31:0] hp_r [2];
  logic signed [31:0] hp_nxt [2];
  logic signed [56:0] acc_r, acc_nxt;
  logic signed [gef_pkg::SAMPLE_BITS-1:0] res_r, res_nxt;

  logic signed [32:0] op_a;
  logic        [23:0] op_b;
  logic signed [56:0] prod;

  logic signed [31:0] x_in;
  logic signed [31:0] lp_sel, hp_sel;
  logic signed [24:0] tb_diff, bt_diff;
  logic        [24:0] t_sum;
  logic signed [25:0] b_sub;
  logic        [23:0] bass_c;
  logic        [16:0] wet_c;
  logic signed [32:0] wet_y;
  logic signed [57:0] mix_sum, mix_sh;

  gef_mul u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  assign x_in    = 32'(in_sample) <<< gef_pkg::SAMPLE_PAD;
  assign lp_sel  = lp_r[phase_r];
  assign hp_sel  = hp_r[phase_r];
  assign tb_diff = $signed({1'b0, treble_r}) - $signed({1'b0, bass_r});
  assign bt_diff = $signed({1'b0, bass_r}) - $signed({1'b0, treble_r});
  assign t_sum   = {1'b0, treble_r} + {1'b0, atk_r};
  assign b_sub   = $signed({2'b00, bass_r}) - $signed({1'b0, atk_r, 1'b0});
  assign bass_c  = (bass_r > gef_pkg::ENV_ONE) ? gef_pkg::ENV_ONE : bass_r;
  assign wet_c   = (cfg.wet_mix > gef_pkg::WET_ONE) ? gef_pkg::WET_ONE : cfg.wet_mix;
  assign wet_y   = (treble_r > bass_r) ? (33'(lp_sel) - 33'(hp_sel)) : 33'sd0;
  assign mix_sum = 58'(acc_r) + 58'(prod);
  assign mix_sh  = mix_sum >>> gef_pkg::MIX_SHIFT;

  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    treble_nxt = treble_r;
    bass_nxt   = bass_r;
    x_nxt      = x_r;
    mag_nxt    = mag_r;
    atk_nxt    = atk_r;
    lp_nxt     = lp_r;
    hp_nxt     = hp_r;
    acc_nxt    = acc_r;
    res_nxt    = res_r;
    op_a       = 33'sd0;
    op_b       = 24'd0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          x_nxt     = x_in;
          mag_nxt   = x_in[31] ? (32'd0 - x_in) : x_in;
          state_nxt = ST_ATK_MUL;
        end
      end
      ST_ATK_MUL: begin
        op_a      = $signed({1'b0, mag_r});
        op_b      = cfg.attack_rate;
        state_nxt = ST_ATK_USE;
      end
      ST_ATK_USE: begin
        // The magnitude never exceeds one, so the step stays non-negative.
        atk_nxt   = cfg.attack_rate - prod[55:32];
        state_nxt = ST_GATE;
      end
      ST_GATE: begin
        if (mag_r > {1'b0, cfg.gate_threshold, 8'd0}) begin
          treble_nxt = (t_sum > {1'b0, gef_pkg::ENV_TWO}) ? gef_pkg::ENV_TWO : t_sum[23:0];
          bass_nxt   = b_sub[25] ? 24'd0 : b_sub[23:0];
          lp_nxt[0]  = x_r;
          lp_nxt[1]  = x_r;
          hp_nxt[0]  = 32'sd0;
          hp_nxt[1]  = 32'sd0;
          state_nxt  = ST_LP_MUL;
        end else begin
          state_nxt  = ST_DT_MUL;
        end
      end
      ST_DT_MUL: begin
        op_a      = 33'(tb_diff);
        op_b      = cfg.treble_decay_mult;
        state_nxt = ST_DT_USE;
      end
      ST_DT_USE: begin
        treble_nxt = bass_r + 24'(prod >>> 24);
        state_nxt  = ST_DB_MUL;
      end
      ST_DB_MUL: begin
        op_a      = 33'(bt_diff);
        op_b      = cfg.bass_decay_mult;
        state_nxt = ST_DB_USE;
      end
      ST_DB_USE: begin
        bass_nxt  = treble_r + 24'(prod >>> 24);
        state_nxt = ST_LP_MUL;
      end
      ST_LP_MUL: begin
        if (treble_r >= gef_pkg::ENV_ONE) begin
          lp_nxt[phase_r] = x_r;
          state_nxt       = ST_HP_MUL;
        end else begin
          op_a      = 33'(x_r) - 33'(lp_sel);
          op_b      = treble_r;
          state_nxt = ST_LP_USE;
        end
      end
      ST_LP_USE: begin
        lp_nxt[phase_r] = lp_sel + 32'(prod >>> 22);
        state_nxt       = ST_HP_MUL;
      end
      ST_HP_MUL: begin
        bass_nxt = bass_c;
        if (bass_c == 24'd0) begin
          hp_nxt[phase_r] = 32'sd0;
          state_nxt       = ST_MD_MUL;
        end else begin
          op_a      = 33'(x_r) - 33'(hp_sel);
          op_b      = bass_c;
          state_nxt = ST_HP_USE;
        end
      end
      ST_HP_USE: begin
        hp_nxt[phase_r] = hp_sel + 32'(prod >>> 22);
        state_nxt       = ST_MD_MUL;
      end
      ST_MD_MUL: begin
        op_a      = 33'(x_r);
        op_b      = 24'(gef_pkg::WET_ONE - wet_c);
        state_nxt = ST_MW_MUL;
      end
      ST_MW_MUL: begin
        acc_nxt   = prod;
        op_a      = wet_y;
        op_b      = 24'(wet_c);
        state_nxt = ST_MW_USE;
      end
      ST_MW_USE: begin
        if (mix_sh > SAT_HI) begin
          res_nxt = SAT_HI[gef_pkg::SAMPLE_BITS-1:0];
        end else if (mix_sh < SAT_LO) begin
          res_nxt = SAT_LO[gef_pkg::SAMPLE_BITS-1:0];
        end else begin
          res_nxt = mix_sh[gef_pkg::SAMPLE_BITS-1:0];
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (slot_free) begin
          phase_nxt = ~phase_r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      phase_r  <= 1'b0;
      treble_r <= gef_pkg::ENV_ONE;
      bass_r   <= 24'd0;
      lp_r[0]  <= 32'sd0;
      lp_r[1]  <= 32'sd0;
      hp_r[0]  <= 32'sd0;
      hp_r[1]  <= 32'sd0;
    end else begin
      state_r  <= state_nxt;
      phase_r  <= phase_nxt;
      treble_r <= treble_nxt;
      bass_r   <= bass_nxt;
      lp_r     <= lp_nxt;
      hp_r     <= hp_nxt;
    end
    x_r   <= x_nxt;
    mag_r <= mag_nxt;
    atk_r <= atk_nxt;
    acc_r <= acc_nxt;
    res_r <= res_nxt;
  end

  assign in_ready   = (state_r == ST_IDLE);
  assign res_valid  = (state_r == ST_DONE);
  assign res_sample = res_r;

endmodule
`default_nettype wire

// ===== rtl/core/gated_envelope_filter_top.sv =====
`default_nettype none
// Each accepted word runs the attack, gate, decay, filter and mix steps; an
// open gate skips decay, and a filter update needing no product skips the
// multiplier. No word is taken before the last is done. One shared 33 x 24
// bit multiplier carries every product in turn under the sequencer in gef_core.
// Reset: synchronous, active-low rst_n restores the envelopes, filter states,
// phase and all configuration registers to their defaults.
module gated_envelope_filter_top (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // Input stream.
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [gef_pkg::DATA_W-1:0]         in_tdata,   // [23:0] in_sample
  // Result stream.
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [gef_pkg::DATA_W-1:0]              out_tdata,  // [23:0] out_sample
  // Configuration write port.
  input  wire logic                               cfg_we,
  input  wire logic [gef_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  wire logic [gef_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  gef_pkg::cfg_t cfg;

  logic                                     slot_free;
  logic                                     res_valid;
  logic signed [gef_pkg::SAMPLE_BITS-1:0]   res_sample;

  // Output register: holds a finished word while the core already takes the
  // next input word.
  logic                                     out_valid_r;
  logic        [gef_pkg::SAMPLE_BITS-1:0]   out_data_r;

  gef_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  gef_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_sample  ($signed(in_tdata[gef_pkg::SAMPLE_BITS-1:0])),
    .slot_free  (slot_free),
    .res_valid  (res_valid),
    .res_sample (res_sample)
  );

  // The slot is free when empty or when its word leaves in this cycle.
  assign slot_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (res_valid && slot_free) begin
      out_data_r <= res_sample;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = gef_pkg::DATA_W'(out_data_r);

endmodule
`default_nettype wire
